@@ hw/rtl/rc4_pkg.sv @@
// Shared types and codes for the RC4 stream cipher core.
// Depends on nothing; rc4_stream_cipher_core imports it.
package rc4_pkg;

    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    localparam logic [1:0] ST_DATA  = 2'd0;
    localparam logic [1:0] ST_KEYED = 2'd1;
    localparam logic [1:0] ST_NOKEY = 2'd2;

    localparam int SBOX_DEPTH = 256;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       end_of_message;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RESULT,
        S_D_J,
        S_D_T,
        S_D_OUT,
        S_K_INIT,
        S_K_RD,
        S_K_J,
        S_K_WN,
        S_K_WJ
    } state_t;

endpackage

@@ hw/rtl/rc4_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read data.
// Depends on nothing; used for the key store and the S-box.
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/rc4_stream_cipher_core.sv @@
// RC4 stream cipher core: top level with control sequencer and S-box datapath.
// Depends on rc4_pkg and rc4_ram.
//
// Key bytes (command 0) are written into a key store one per transfer; bytes
// beyond KEY_MAX are dropped. A key byte with last set starts the key schedule:
// a sweep that loads the identity permutation into the S-box memory, then 256
// swap steps (read S[n] and key byte, read S[j], write S[n], write S[j]),
// after which one key-ready result (status 1) is returned and both indices are
// cleared. A key byte that is not last returns no result and leaves the core
// ready for the next item. A data byte (command 1) passes through S_D_J, S_D_T
// and S_D_OUT before the core can take the next item: the S-box has one read
// and one write port with registered read data, and the chain read S[i],
// read S[j], swap and read S[S[i]+S[j]] is dependent from step to step. Where
// the final read hits an entry being swapped in the same cycle, the value is
// forwarded from the datapath registers. A data byte that arrives before any
// key has been scheduled returns zero with status 2 and changes no state.
// Results sit in an output register, so a result that waits for its transfer
// stalls the core only when the next result is ready to leave.
module rc4_stream_cipher_core
    import rc4_pkg::*;
#(
    parameter int KEY_MAX = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  in_item_t  req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output out_item_t rsp
);

    localparam int KIDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int CNT_W  = $clog2(KEY_MAX + 1);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  key_count_reg, key_count_next;
    logic [CNT_W-1:0]  sched_len_reg, sched_len_next;
    logic [KIDX_W-1:0] kidx_reg, kidx_next;
    logic [7:0]        n_reg, n_next;
    logic [7:0]        i_reg, i_next;
    logic [7:0]        j_reg, j_next;
    logic              keyed_reg, keyed_next;

    logic [7:0]        si_reg, si_next;
    logic [7:0]        byte_reg, byte_next;
    logic              last_reg, last_next;
    logic              fwd_reg, fwd_next;
    logic [7:0]        fwd_val_reg, fwd_val_next;

    out_item_t         res_reg, res_next;
    out_item_t         out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic              s_we, s_re;
    logic [7:0]        s_waddr, s_wdata, s_raddr, s_rdata;
    logic              k_we, k_re;
    logic [KIDX_W-1:0] k_waddr;
    logic [7:0]        k_rdata;

    logic              accept;
    logic              slot_free;
    logic              deliver;
    out_item_t         deliver_item;
    logic [CNT_W-1:0]  count_inc;
    logic [7:0]        t_addr;
    logic [7:0]        keystream;

    rc4_ram #(
        .WIDTH(8),
        .DEPTH(SBOX_DEPTH)
    ) u_sbox (
        .clk  (clk),
        .we   (s_we),
        .waddr(s_waddr),
        .wdata(s_wdata),
        .re   (s_re),
        .raddr(s_raddr),
        .rdata(s_rdata)
    );

    rc4_ram #(
        .WIDTH(8),
        .DEPTH(KEY_MAX)
    ) u_key_store (
        .clk  (clk),
        .we   (k_we),
        .waddr(k_waddr),
        .wdata(req.data_byte),
        .re   (k_re),
        .raddr(kidx_reg),
        .rdata(k_rdata)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign slot_free = !out_valid_reg || rsp_ready;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign k_waddr   = key_count_reg[KIDX_W-1:0];
    assign count_inc = key_count_reg + CNT_W'(1);
    assign t_addr    = si_reg + s_rdata;
    assign keystream = fwd_reg ? fwd_val_reg : s_rdata;

    always_comb
    begin
        state_next     = state_reg;
        key_count_next = key_count_reg;
        sched_len_next = sched_len_reg;
        kidx_next      = kidx_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        keyed_next     = keyed_reg;
        si_next        = si_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        fwd_next       = fwd_reg;
        fwd_val_next   = fwd_val_reg;
        res_next       = res_reg;
        s_we           = 1'b0;
        s_waddr        = n_reg;
        s_wdata        = n_reg;
        s_re           = 1'b0;
        s_raddr        = n_reg;
        k_we           = 1'b0;
        k_re           = 1'b0;
        deliver        = 1'b0;
        deliver_item   = res_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.command == CMD_KEY)
                    begin
                        if (key_count_reg < CNT_W'(KEY_MAX))
                        begin
                            k_we           = 1'b1;
                            key_count_next = count_inc;
                            sched_len_next = count_inc;
                        end
                        else
                        begin
                            sched_len_next = key_count_reg;
                        end
                        if (req.last)
                        begin
                            key_count_next = '0;
                            n_next         = '0;
                            j_next         = '0;
                            kidx_next      = '0;
                            state_next     = S_K_INIT;
                        end
                    end
                    else if (!keyed_reg)
                    begin
                        deliver      = 1'b1;
                        deliver_item = '{out_byte: 8'h00, status: ST_NOKEY,
                                         end_of_message: req.last};
                    end
                    else
                    begin
                        i_next     = i_reg + 8'd1;
                        s_re       = 1'b1;
                        s_raddr    = i_reg + 8'd1;
                        byte_next  = req.data_byte;
                        last_next  = req.last;
                        state_next = S_D_J;
                    end
                end
            end

            S_D_J:
            begin
                // S[i] has arrived; advance j and fetch S[j].
                si_next    = s_rdata;
                j_next     = j_reg + s_rdata;
                s_re       = 1'b1;
                s_raddr    = j_reg + s_rdata;
                state_next = S_D_T;
            end

            S_D_T:
            begin
                // Write S[i] = old S[j] and fetch the keystream entry. The entry
                // at j is still stale in memory, and the one at i is written in
                // this same cycle, so both are forwarded.
                s_we         = 1'b1;
                s_waddr      = i_reg;
                s_wdata      = s_rdata;
                s_re         = 1'b1;
                s_raddr      = t_addr;
                fwd_next     = (t_addr == j_reg) || (t_addr == i_reg);
                fwd_val_next = (t_addr == j_reg) ? si_reg : s_rdata;
                state_next   = S_D_OUT;
            end

            S_D_OUT:
            begin
                s_we         = 1'b1;
                s_waddr      = j_reg;
                s_wdata      = si_reg;
                deliver      = 1'b1;
                deliver_item = '{out_byte: byte_reg ^ keystream, status: ST_DATA,
                                 end_of_message: last_reg};
            end

            S_RESULT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end

            S_K_INIT:
            begin
                s_we    = 1'b1;
                s_waddr = n_reg;
                s_wdata = n_reg;
                n_next  = n_reg + 8'd1;
                if (n_reg == 8'hFF)
                begin
                    state_next = S_K_RD;
                end
            end

            S_K_RD:
            begin
                s_re       = 1'b1;
                s_raddr    = n_reg;
                k_re       = 1'b1;
                state_next = S_K_J;
            end

            S_K_J:
            begin
                si_next    = s_rdata;
                j_next     = j_reg + k_rdata + s_rdata;
                s_re       = 1'b1;
                s_raddr    = j_reg + k_rdata + s_rdata;
                state_next = S_K_WN;
            end

            S_K_WN:
            begin
                s_we       = 1'b1;
                s_waddr    = n_reg;
                s_wdata    = s_rdata;
                state_next = S_K_WJ;
            end

            S_K_WJ:
            begin
                s_we    = 1'b1;
                s_waddr = j_reg;
                s_wdata = si_reg;
                n_next  = n_reg + 8'd1;
                if (CNT_W'(kidx_reg) + CNT_W'(1) == sched_len_reg)
                begin
                    kidx_next = '0;
                end
                else
                begin
                    kidx_next = kidx_reg + KIDX_W'(1);
                end
                if (n_reg == 8'hFF)
                begin
                    i_next       = '0;
                    j_next       = '0;
                    keyed_next   = 1'b1;
                    deliver      = 1'b1;
                    deliver_item = '{out_byte: 8'h00, status: ST_KEYED,
                                     end_of_message: 1'b0};
                end
                else
                begin
                    state_next = S_K_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A finished result goes straight to the output register when it is
        // free; otherwise it is parked and the sequencer waits in S_RESULT.
        if (deliver)
        begin
            res_next   = deliver_item;
            state_next = slot_free ? S_IDLE : S_RESULT;
        end
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        if (deliver && slot_free)
        begin
            out_next       = deliver_item;
            out_valid_next = 1'b1;
        end
        else if (state_reg == S_RESULT && slot_free)
        begin
            out_next       = res_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            key_count_reg <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            keyed_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            key_count_reg <= key_count_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            keyed_reg     <= keyed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sched_len_reg <= sched_len_next;
        kidx_reg      <= kidx_next;
        n_reg         <= n_next;
        si_reg        <= si_next;
        byte_reg      <= byte_next;
        last_reg      <= last_next;
        fwd_reg       <= fwd_next;
        fwd_val_reg   <= fwd_val_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

endmodule

@@ tb/tb_rc4_stream_cipher_core.sv @@
// Self-checking testbench for rc4_stream_cipher_core: a keystream predictor
// and a result queue check every output transfer against the expected byte.
// Depends on rc4_pkg and the core RTL; reads no files and needs no arguments.
import rc4_pkg::*;

class rc4_keystream_scoreboard;
    int unsigned key_limit;
    logic [7:0] key_mem [256];
    bit   [8:0] key_len;
    logic [7:0] perm [256];
    bit   [7:0] ptr_i;
    bit   [7:0] ptr_j;
    bit         have_key;
    out_item_t  expected_q [$];
    int         errors;

    function new(int unsigned limit);
        key_limit = limit;
        key_len   = '0;
        ptr_i     = '0;
        ptr_j     = '0;
        have_key  = 1'b0;
        errors    = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // Prints one line per mismatch and counts it.
    task report_mismatch(string msg);
        errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Advances the predicted cipher state by one accepted input transfer and
    // queues the result that the core owes for it, if any.
    function void note_transfer_in(in_item_t item);
        out_item_t   res;
        bit [7:0]    swing;
        bit [7:0]    tmp;
        bit [7:0]    sum;
        int unsigned len;
        res                = '0;
        res.end_of_message = item.last;
        if (item.command == CMD_KEY)
        begin
            if (key_len < key_limit)
            begin
                key_mem[key_len[7:0]] = item.data_byte;
                key_len++;
            end
            if (!item.last)
                return;
            len = (key_len == 0) ? 1 : key_len;
            for (int n = 0; n < SBOX_DEPTH; n++)
                perm[n] = n[7:0];
            swing = '0;
            for (int n = 0; n < SBOX_DEPTH; n++)
            begin
                swing       = swing + key_mem[n % len] + perm[n];
                tmp         = perm[n];
                perm[n]     = perm[swing];
                perm[swing] = tmp;
            end
            ptr_i              = '0;
            ptr_j              = '0;
            key_len            = '0;
            have_key           = 1'b1;
            res.status         = ST_KEYED;
            res.end_of_message = 1'b0;
        end
        else if (!have_key)
        begin
            res.status = ST_NOKEY;
        end
        else
        begin
            ptr_i       = ptr_i + 8'd1;
            ptr_j       = ptr_j + perm[ptr_i];
            tmp         = perm[ptr_i];
            perm[ptr_i] = perm[ptr_j];
            perm[ptr_j] = tmp;
            sum         = perm[ptr_i] + perm[ptr_j];
            res.out_byte = item.data_byte ^ perm[sum];
            res.status   = ST_DATA;
        end
        expected_q.push_back(res);
    endfunction

    task check_transfer_out(out_item_t got);
        out_item_t want;
        if (expected_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result byte=%02h status=%0d eom=%0b",
                                      got.out_byte, got.status, got.end_of_message));
            return;
        end
        want = expected_q.pop_front();
        if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      got.out_byte, want.out_byte));
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.end_of_message !== want.end_of_message)
            report_mismatch($sformatf("end_of_message %0b, expected %0b",
                                      got.end_of_message, want.end_of_message));
    endtask
endclass

module tb_rc4_stream_cipher_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_MAX        = 256;
    localparam int ITEM_TARGET    = 1750;
    localparam int PHASE_ITEMS    = 200;
    // A key schedule alone keeps both channels quiet throughout, so the watchdog
    // limit is set well above its length before it gives up.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int END_DRAIN      = 64;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_e;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    in_item_t  req = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    out_item_t rsp;

    rc4_keystream_scoreboard sb;
    idle_mode_e idle_mode = IDLE_NONE;
    int items_sent   = 0;
    int quiet_cycles = 0;

    rc4_stream_cipher_core #(
        .KEY_MAX(KEY_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    always #4 clk = ~clk;

    // The testbench drives on the falling edge and samples on the rising
    // edge, so nothing here depends on event order inside one time step.

    // Receiver: ready is redrawn every cycle according to the stall mode.
    // In the modes without receiver stalls it simply stays high.
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else if (idle_mode == IDLE_RECEIVER)
            rsp_ready <= ($urandom_range(99) >= 80);
        else if (idle_mode == IDLE_BOTH)
            rsp_ready <= ($urandom_range(99) >= 25);
        else
            rsp_ready <= 1'b1;
    end

    // Every output transfer is checked against the oldest expected result.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_transfer_out(rsp);
    end

    // Watchdog: counts cycles in which neither channel completes a transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Offers one input item and returns once the core has taken it. Random
    // idle cycles are inserted ahead of the item in the sender idle modes.
    // Valid stays high across back-to-back items, so it is never lowered and
    // raised in the same time step.
    task automatic send_item(logic cmd, logic [7:0] value, logic is_last);
        in_item_t item;
        int unsigned gap_pct;
        item.command   = cmd;
        item.data_byte = value;
        item.last      = is_last;
        gap_pct = (idle_mode == IDLE_SENDER) ? 80 : (idle_mode == IDLE_BOTH) ? 25 : 0;
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_transfer_in(item);
        items_sent++;
    endtask

    // Sends a run of random bytes of one kind, with last set on the final
    // byte: a whole key or a whole message.
    task automatic send_run(logic cmd, int unsigned len);
        for (int unsigned k = 0; k < len; k++)
            send_item(cmd, 8'($urandom_range(255)), (k == len - 1));
    endtask

    // Holds the sender off until the core has returned every owed result.
    task automatic wait_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned pick;
        int unsigned key_len;
        int next_switch;
        sb = new(KEY_MAX);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Data before any key must come back as no-key with
        // the last flag echoed, at both byte extremes.
        send_item(CMD_DATA, 8'h00, 1'b0);
        send_item(CMD_DATA, 8'hFF, 1'b1);
        // A one-byte key, then a short message over it.
        send_item(CMD_KEY, 8'hFF, 1'b1);
        send_item(CMD_DATA, 8'h00, 1'b0);
        send_item(CMD_DATA, 8'hFF, 1'b0);
        send_item(CMD_DATA, 8'hA5, 1'b1);
        // The classic three-byte key "Key" with the message "Plaintext".
        send_item(CMD_KEY, 8'h4B, 1'b0);
        send_item(CMD_KEY, 8'h65, 1'b0);
        send_item(CMD_KEY, 8'h79, 1'b1);
        send_item(CMD_DATA, 8'h50, 1'b0);
        send_item(CMD_DATA, 8'h6C, 1'b0);
        send_item(CMD_DATA, 8'h61, 1'b0);
        send_item(CMD_DATA, 8'h69, 1'b0);
        send_item(CMD_DATA, 8'h6E, 1'b0);
        send_item(CMD_DATA, 8'h74, 1'b0);
        send_item(CMD_DATA, 8'h65, 1'b0);
        send_item(CMD_DATA, 8'h78, 1'b0);
        send_item(CMD_DATA, 8'h74, 1'b1);
        // A new key is half collected while data still runs on the old S-box.
        send_item(CMD_KEY, 8'h00, 1'b0);
        send_item(CMD_DATA, 8'h5A, 1'b1);
        send_item(CMD_KEY, 8'h80, 1'b1);
        send_item(CMD_DATA, 8'h3C, 1'b1);

        // Random part. An overlong key comes first so that dropping bytes past
        // the key store limit is always exercised.
        send_run(CMD_KEY, 300);
        send_run(CMD_DATA, 16);
        next_switch = items_sent;
        while (items_sent < ITEM_TARGET)
        begin
            // Idle modes rotate every few hundred items. Before each switch
            // the sender pauses until every owed result has come back.
            if (items_sent >= next_switch)
            begin
                wait_drained();
                idle_mode   = idle_mode_e'((int'(idle_mode) + 1) % 4);
                next_switch = next_switch + PHASE_ITEMS;
            end
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                // Noise: a few items with every field random.
                repeat ($urandom_range(4, 1))
                    send_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                              1'($urandom_range(1)));
            end
            else
            begin
                // Well-formed traffic: a key, then one to three messages.
                key_len = ($urandom_range(99) < 6) ? $urandom_range(300, 200)
                                                   : $urandom_range(24, 1);
                send_run(CMD_KEY, key_len);
                repeat ($urandom_range(3, 1))
                    send_run(CMD_DATA, $urandom_range(48, 1));
            end
        end

        wait_drained();
        // Trailing key bytes owe no result, so give the core time to show
        // any spurious output before the verdict.
        repeat (END_DRAIN) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
